// File: hw/rtl/button_click_classifier_macros.svh
// assertion helpers for the checks in bcc_classify
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, quiet during reset
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bcc_pkg.sv
`timescale 1ns / 1ps
package bcc_pkg;

  // field and port widths
  localparam int STAMP_W     = 32;
  localparam int LIMIT_W     = 32;
  localparam int TICKS_W     = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // default timestamp storage width
  localparam int STAMP_BITS_DEF = 32;

  // register reset values
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST = 32'd550000;
  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST  = 32'd85000;
  localparam logic [TICKS_W-1:0] WIN_TICKS_RST  = 16'd500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TICKS  = 2'd2;

  // command codes and pin level
  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_TICK    = 1'b1;
  localparam logic PIN_PRESSED = 1'b0;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] long_press_limit;
    logic [LIMIT_W-1:0] double_gap_limit;
    logic [TICKS_W-1:0] window_ticks;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } res_t;

endpackage

// File: hw/rtl/bcc_cfg_regs.sv
`timescale 1ns / 1ps
module bcc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output bcc_pkg::cfg_t                   cfg
);
  import bcc_pkg::*;

  logic [LIMIT_W-1:0] long_limit_r;
  logic [LIMIT_W-1:0] gap_limit_r;
  logic [TICKS_W-1:0] win_ticks_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_limit_r <= LONG_LIMIT_RST;
      gap_limit_r  <= GAP_LIMIT_RST;
      win_ticks_r  <= WIN_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LONG_LIMIT: long_limit_r <= cfg_wdata[LIMIT_W-1:0];
        REG_GAP_LIMIT:  gap_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        REG_WIN_TICKS:  win_ticks_r  <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.long_press_limit = long_limit_r;
  assign cfg.double_gap_limit = gap_limit_r;
  assign cfg.window_ticks     = win_ticks_r;

endmodule

// File: hw/rtl/bcc_classify.sv
`timescale 1ns / 1ps
`include "button_click_classifier_macros.svh"
module bcc_classify #(
  parameter int STAMP_BITS = bcc_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_cmd,
  input  logic                         in_pin_level,
  input  logic [bcc_pkg::STAMP_W-1:0]  in_stamp,
  input  bcc_pkg::cfg_t                cfg,
  input  logic                         out_free,
  output bcc_pkg::res_t                res
);
  import bcc_pkg::*;

  // compare width covers both stamp storage and the 32-bit limits
  localparam int CMP_W = (STAMP_BITS > LIMIT_W) ? STAMP_BITS : LIMIT_W;

  // input register
  logic               in_v_r;
  logic               cmd_r;
  logic               lvl_r;
  logic [STAMP_W-1:0] stamp_r;

  // classifier state
  logic [STAMP_BITS-1:0] press_r, press_nxt;
  logic [STAMP_BITS-1:0] prior_r, prior_nxt;
  logic [STAMP_BITS-1:0] latest_r, latest_nxt;
  logic                  win_open_r, win_open_nxt;
  logic [TICKS_W-1:0]    win_elapsed_r, win_elapsed_nxt;

  logic [STAMP_BITS-1:0] now;
  logic [STAMP_BITS-1:0] hold;
  logic [STAMP_BITS-1:0] gap;
  logic [TICKS_W-1:0]    elapsed_inc;
  logic                  long_hit;
  logic                  dbl_hit;
  logic                  expire;
  logic                  fire;
  res_t                  res_c;

  // arithmetic on the held word
  assign now         = STAMP_BITS'(stamp_r);
  assign hold        = now - press_r;
  assign gap         = latest_r - prior_r;
  assign long_hit    = CMP_W'(hold) > CMP_W'(cfg.long_press_limit);
  assign dbl_hit     = CMP_W'(gap) < CMP_W'(cfg.double_gap_limit);
  assign elapsed_inc = win_elapsed_r + 1'b1;
  assign expire      = elapsed_inc >= cfg.window_ticks;

  // result and next state for the held word
  always_comb begin
    press_nxt       = press_r;
    prior_nxt       = prior_r;
    latest_nxt      = latest_r;
    win_open_nxt    = win_open_r;
    win_elapsed_nxt = win_elapsed_r;
    res_c.valid     = 1'b0;
    res_c.kind      = KIND_SINGLE;
    if (cmd_r == CMD_EDGE) begin
      if (lvl_r == PIN_PRESSED) begin
        press_nxt = now;
      end else if (long_hit) begin
        res_c.valid = 1'b1;
        res_c.kind  = KIND_LONG;
      end else begin
        prior_nxt  = latest_r;
        latest_nxt = now;
        if (!win_open_r) begin
          win_open_nxt    = 1'b1;
          win_elapsed_nxt = '0;
        end
      end
    end else if (win_open_r) begin
      if (expire) begin
        win_open_nxt    = 1'b0;
        win_elapsed_nxt = '0;
        res_c.valid     = 1'b1;
        res_c.kind      = dbl_hit ? KIND_DOUBLE : KIND_SINGLE;
      end else begin
        win_elapsed_nxt = elapsed_inc;
      end
    end
  end

  // a word leaves unless it carries a result and the output is full and not being taken
  assign fire      = in_v_r && (!res_c.valid || out_free);
  assign in_tready = !in_v_r || fire;

  assign res.valid = res_c.valid && fire;
  assign res.kind  = res_c.kind;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_cmd;
      lvl_r   <= in_pin_level;
      stamp_r <= in_stamp;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r       <= '0;
      prior_r       <= '0;
      latest_r      <= '0;
      win_open_r    <= 1'b0;
      win_elapsed_r <= '0;
    end else if (fire) begin
      press_r       <= press_nxt;
      prior_r       <= prior_nxt;
      latest_r      <= latest_nxt;
      win_open_r    <= win_open_nxt;
      win_elapsed_r <= win_elapsed_nxt;
    end
  end

  // checks
  `BCC_ASSERT_NOW(a_closed_count_zero, !win_open_r, win_elapsed_r == '0,
    "tick count not cleared while window closed")
  `BCC_ASSERT_NOW(a_click_from_tick, res.valid && res.kind != KIND_LONG,
    cmd_r == CMD_TICK && win_open_r, "click result without an open window tick")
  `BCC_ASSERT_NEXT(a_expire_closes, res.valid && cmd_r == CMD_TICK, !win_open_r,
    "window still open after expiry")
  `BCC_ASSERT_NEXT(a_long_keeps_window, res.valid && res.kind == KIND_LONG,
    $stable(win_open_r) && $stable(latest_r), "long press disturbed the window")

endmodule

// File: hw/rtl/bcc_out_reg.sv
`timescale 1ns / 1ps
module bcc_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bcc_pkg::res_t                     res,
  output logic                              out_free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bcc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import bcc_pkg::*;

  logic  out_v_r, out_v_nxt;
  kind_t kind_r;

  assign out_free = !out_v_r || out_tready;

  // result holding register
  always_comb begin
    out_v_nxt = out_v_r;
    if (res.valid) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind_r <= res.kind;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'(kind_r);

endmodule

// File: hw/rtl/button_click_classifier.sv
`timescale 1ns / 1ps
// Push-button classifier: takes pin edge words (tuser low) and millisecond
// tick words (tuser high) and reports single clicks, double clicks and long
// presses. One word is accepted per clock; each word that causes a result is
// held in an input register, passes one subtract-and-compare step and is
// written into the result register, which drives out_tvalid. Input ready
// drops only when the word held in the input register would give a result
// while the result register is still full and not being taken.
module button_click_classifier #(
  parameter int STAMP_BITS = bcc_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bcc_pkg::IN_TDATA_W-1:0]    in_tdata,   // pin_level, stamp, zero pad
  input  logic                              in_tuser,   // cmd
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bcc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // event_kind, zero pad
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bcc_pkg::*;

  cfg_t cfg;
  res_t res;
  logic out_free;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcc_classify #(
    .STAMP_BITS (STAMP_BITS)
  ) u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_cmd       (in_tuser),
    .in_pin_level (in_tdata[0]),
    .in_stamp     (in_tdata[STAMP_W:1]),
    .cfg          (cfg),
    .out_free     (out_free),
    .res          (res)
  );

  bcc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import bcc_pkg::*;

  localparam logic PIN_RELEASED   = ~PIN_PRESSED;
  localparam int   WATCHDOG_LIMIT = 5000;
  localparam int   SETTLE_CYCLES  = 8;
  localparam int   PRINT_CAP      = 40;

  // click classification predictor with its queue of pending event kinds
  class click_tracker;
    logic [LIMIT_W-1:0] long_limit;
    logic [LIMIT_W-1:0] gap_limit;
    logic [TICKS_W-1:0] win_ticks;
    logic [STAMP_W-1:0] press_at;
    logic [STAMP_W-1:0] prior_rel;
    logic [STAMP_W-1:0] latest_rel;
    bit                 win_open;
    logic [TICKS_W-1:0] win_count;
    kind_t              pending_kinds[$];
    int unsigned        errors;
    int unsigned        words_seen;
    int unsigned        acting_words;
    int unsigned        predicted;
    int unsigned        kind_hits[3];

    function new();
      long_limit = LONG_LIMIT_RST;
      gap_limit  = GAP_LIMIT_RST;
      win_ticks  = WIN_TICKS_RST;
      press_at   = '0;
      prior_rel  = '0;
      latest_rel = '0;
      win_open   = 1'b0;
      win_count  = '0;
    endfunction

    function void set_limits(logic [LIMIT_W-1:0] long_l, logic [LIMIT_W-1:0] gap_l,
                             logic [TICKS_W-1:0] ticks);
      long_limit = long_l;
      gap_limit  = gap_l;
      win_ticks  = ticks;
    endfunction

    // apply one accepted word to the predicted state
    function void note_word(logic cmd, logic level, logic [STAMP_W-1:0] stamp);
      logic [STAMP_W-1:0] held;
      logic [STAMP_W-1:0] rel_gap;
      words_seen++;
      if (cmd == CMD_EDGE) begin
        acting_words++;
        if (level == PIN_PRESSED) begin
          press_at = stamp;
          return;
        end
        held = stamp - press_at;
        if (held > long_limit) begin
          pending_kinds.push_back(KIND_LONG);
          predicted++;
          return;
        end
        prior_rel  = latest_rel;
        latest_rel = stamp;
        if (!win_open) begin
          win_open  = 1'b1;
          win_count = '0;
        end
      end else if (win_open) begin
        // ticks only matter while a window runs
        acting_words++;
        win_count = win_count + 1'b1;
        if (win_count >= win_ticks) begin
          win_open  = 1'b0;
          win_count = '0;
          rel_gap   = latest_rel - prior_rel;
          pending_kinds.push_back(rel_gap < gap_limit ? KIND_DOUBLE : KIND_SINGLE);
          predicted++;
        end
      end
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP)
        $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // compare one accepted result word with the oldest prediction
    task check_event(logic [1:0] got);
      kind_t want;
      if (pending_kinds.size() == 0) begin
        report_mismatch($sformatf("unexpected result, event_kind %0d", got));
        return;
      end
      want = pending_kinds.pop_front();
      if (got !== want)
        report_mismatch($sformatf("event_kind %0d, expected %s", got, want.name()));
      else
        kind_hits[want]++;
    endtask

    function int pending();
      return pending_kinds.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  click_tracker tracker;
  int           tx_idle_pct;
  int           rx_stall_pct;
  int           hold_req;
  int           hold_seq;
  int           hold_seen;
  int           hold_left;
  int           quiet_cycles;
  int           settings_run;
  logic [STAMP_W-1:0] t_now;
  logic [STAMP_W-1:0] last_rel;

  always #2 clk = ~clk;

  button_click_classifier u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    logic ready_next;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = ($urandom_range(0, 99) >= rx_stall_pct);
    end
    out_tready <= ready_next;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_event(out_tdata[1:0]);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               quiet_cycles, tracker.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one word, idling first at random, and wait for acceptance
  task automatic send_word(input logic cmd, input logic level, input logic [STAMP_W-1:0] stamp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W-STAMP_W-1){1'b0}}, stamp, level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_word(cmd, level, stamp);
  endtask

  task automatic send_edge(input logic level, input logic [STAMP_W-1:0] stamp);
    send_word(CMD_EDGE, level, stamp);
  endtask

  // tick fields other than cmd are don't-care, so fill them at random
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++)
      send_word(CMD_TICK, 1'($urandom_range(0, 1)), $urandom);
  endtask

  // write all three registers, block idle
  task automatic write_cfg(input logic [LIMIT_W-1:0] long_l, input logic [LIMIT_W-1:0] gap_l,
                           input logic [TICKS_W-1:0] ticks);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LONG_LIMIT;
    cfg_wdata <= long_l;
    @(posedge clk);
    cfg_index <= REG_GAP_LIMIT;
    cfg_wdata <= gap_l;
    @(posedge clk);
    cfg_index <= REG_WIN_TICKS;
    cfg_wdata <= {{(CFG_DATA_W-TICKS_W){1'b0}}, ticks};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_limits(long_l, gap_l, ticks);
    settings_run++;
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a value on, around or away from a limit
  function automatic logic [STAMP_W-1:0] near_limit(input logic [STAMP_W-1:0] limit);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return limit - 1'b1;
      2: return limit;
      3: return limit + 1'b1;
      4: return $urandom_range(0, limit);
      5: return limit + $urandom_range(0, limit);
      default: return $urandom;
    endcase
  endfunction

  // mostly press/release gestures with random timing, some noise words
  task automatic run_phase(input logic [LIMIT_W-1:0] long_l, input logic [LIMIT_W-1:0] gap_l,
                           input logic [TICKS_W-1:0] ticks, input int word_target,
                           input int tx_pct, input int rx_pct, input int hold_len);
    int unsigned words0;
    int unsigned events0;
    logic [STAMP_W-1:0] gap;
    logic [STAMP_W-1:0] rel;
    int roll;
    int win;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    write_cfg(long_l, gap_l, ticks);
    if (hold_len > 0) begin
      hold_req = hold_len;
      hold_seq++;
    end
    words0  = tracker.acting_words;
    events0 = tracker.predicted;
    win     = int'(ticks);
    while (tracker.acting_words - words0 < word_target || tracker.predicted - events0 < 12) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      end else if (roll < 55) begin
        // hold length aimed at the long-press limit
        t_now = t_now + $urandom_range(0, 2000);
        send_edge(PIN_PRESSED, t_now);
        t_now = t_now + near_limit(long_l);
        send_edge(PIN_RELEASED, t_now);
        last_rel = t_now;
      end else begin
        // release spacing aimed at the double-click limit
        gap = near_limit(gap_l);
        rel = last_rel + gap;
        send_edge(PIN_PRESSED, last_rel + $urandom_range(0, gap));
        send_edge(PIN_RELEASED, rel);
        last_rel = rel;
        t_now    = rel;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50)
        send_ticks($urandom_range(0, win / 4 + 1));
      else if (roll < 70)
        send_ticks(win + 1);
    end
    drain();
  endtask

  initial begin
    logic [STAMP_W-1:0] base;
    tracker      = new();
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= CMD_EDGE;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_LONG_LIMIT;
    cfg_wdata    <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 0;
    hold_seq     = 0;
    settings_run = 0;
    t_now        = $urandom;
    last_rel     = t_now;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: limits at their edges, long press mid-window, wrap-around
    write_cfg(32'd1000, 32'd300, 16'd3);
    base = 32'hFFFF_FF00;
    send_word(CMD_TICK, PIN_RELEASED, 32'hFFFF_FFFF);  // no window: ignored
    send_edge(PIN_PRESSED, base);
    send_edge(PIN_RELEASED, base + 32'd1000);          // hold equal to limit: short
    send_edge(PIN_PRESSED, base + 32'd1100);
    send_edge(PIN_RELEASED, base + 32'd2101);          // long while window runs
    send_edge(PIN_PRESSED, base + 32'd2200);
    send_edge(PIN_RELEASED, base + 32'd2200);          // zero hold, wide gap
    send_ticks(3);
    send_edge(PIN_PRESSED, base + 32'd3000);
    send_edge(PIN_RELEASED, base + 32'd3010);
    send_edge(PIN_PRESSED, base + 32'd3050);           // repeated fall
    send_edge(PIN_PRESSED, base + 32'd3100);
    send_edge(PIN_RELEASED, base + 32'd3309);          // gap one under limit
    send_edge(PIN_RELEASED, base + 32'd3609);          // repeated rise, gap on limit
    send_ticks(3);
    send_edge(PIN_PRESSED, 32'h0000_0000);
    send_edge(PIN_RELEASED, 32'hFFFF_FFFF);            // largest hold
    send_edge(PIN_PRESSED, 32'hFFFF_FFFF);
    send_edge(PIN_RELEASED, 32'h0000_0000);            // hold wraps to one
    send_ticks(3);
    drain();

    // random phases over several limit settings and idling patterns
    run_phase(32'd0,          32'd0,          16'd1,   200, 0,  0,  300);
    run_phase(32'hFFFF_FFFF,  32'hFFFF_FFFF,  16'd2,   200, 46, 0,  0);
    run_phase(32'd1000,       32'd300,        16'd0,   200, 0,  46, 0);
    run_phase(32'd2000,       32'd500,        16'd7,   250, 15, 15, 0);
    run_phase(LONG_LIMIT_RST, GAP_LIMIT_RST,  16'd60,  250, 0,  0,  0);
    run_phase(32'd40,         32'd25,         16'd4,   200, 46, 46, 0);

    // widest window stays open, with a short release partway through,
    // then a one-tick window closes it on the next tick
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_cfg(32'd100, 32'd50, 16'hFFFF);
    send_edge(PIN_PRESSED, t_now);
    send_edge(PIN_RELEASED, t_now + 32'd5);
    send_ticks(100);
    send_edge(PIN_PRESSED, t_now + 32'd20);
    send_edge(PIN_RELEASED, t_now + 32'd40);
    send_ticks(100);
    drain();
    write_cfg(32'd100, 32'd50, 16'd1);
    send_ticks(1);
    drain();

    $display("run covered %0d words (%0d acting on state) over %0d limit settings",
             tracker.words_seen, tracker.acting_words, settings_run);
    $display("results checked: %0d single, %0d double, %0d long press",
             tracker.kind_hits[KIND_SINGLE], tracker.kind_hits[KIND_DOUBLE],
             tracker.kind_hits[KIND_LONG]);
    if (tracker.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
